@@ design/tma_pkg.sv @@
// shared types, constants and helper functions of the mixed-radix time alu
package tma_pkg;

   localparam int NW          = 28;
   localparam int KW          = 24;
   localparam int DW          = 25;
   localparam int RW          = 16;
   localparam int DIV_STEPS   = DW;
   localparam int DIV_COUNT   = 4;
   localparam int NORM_STAGES = 6;
   localparam int LATENCY     = 1 + DIV_COUNT * (DIV_STEPS + 1) + NORM_STAGES;
   localparam int EST_SHIFT   = 28;

   localparam logic signed [15:0]   INF_HOURS   = 16'sd32767;
   localparam logic [5:0]           INF_MINUTES = 6'd59;
   localparam logic [5:0]           INF_SECONDS = 6'd59;
   localparam logic [9:0]           INF_MILLIS  = 10'd999;
   localparam logic signed [15:0]   BAD_HOURS   = -16'sd1;

   localparam logic signed [11:0]   MS_RADIX = 12'sd1000;
   localparam logic signed [11:0]   SM_RADIX = 12'sd60;
   localparam logic signed [KW-1:0] K_MS     = 24'sd268435;
   localparam logic signed [KW-1:0] K_SM     = 24'sd4473924;

   typedef enum logic [1:0] {
      ACT_ADD,
      ACT_SUB,
      ACT_MUL,
      ACT_DIV
   } tma_action_type;

   typedef enum logic [1:0] {
      FIX_NONE,
      FIX_INF,
      FIX_BAD
   } tma_fix_type;

   typedef enum logic [1:0] {
      SLOT_H,
      SLOT_M,
      SLOT_S,
      SLOT_MS
   } tma_slot_type;

   typedef struct packed {
      tma_action_type     action;
      logic signed [15:0] a_hours;
      logic [5:0]         a_minutes;
      logic [5:0]         a_seconds;
      logic [9:0]         a_millis;
      logic signed [15:0] b_hours;
      logic [5:0]         b_minutes;
      logic [5:0]         b_seconds;
      logic [9:0]         b_millis;
      logic signed [15:0] factor;
   } tma_req_type;

   typedef struct packed {
      logic signed [31:0] res_hours;
      logic [5:0]         res_minutes;
      logic [5:0]         res_seconds;
      logic [9:0]         res_millis;
      logic               a_less;
      logic               a_equal;
   } tma_rsp_type;

   typedef struct packed {
      logic               is_div;
      tma_fix_type        fix;
      logic               less;
      logic               equal;
      logic signed [31:0] t_h;
      logic signed [NW-1:0] t_m;
      logic signed [NW-1:0] t_s;
      logic signed [NW-1:0] t_ms;
      logic [RW-1:0]      d_mag;
      logic               d_neg;
      logic               n_neg;
      logic [5:0]         a_m;
      logic [5:0]         a_s;
      logic [9:0]         a_ms;
   } tma_ctx_type;

   typedef struct packed {
      logic [DW-1:0] num;
      logic [RW-1:0] rem;
   } tma_div_type;

   typedef struct packed {
      logic signed [NW-1:0] q;
      logic [9:0]           r;
   } tma_carry_type;

   // floor quotient estimate, off by at most one
   function automatic logic signed [NW-1:0] quot_est(input logic signed [NW-1:0] x,
                                                     input logic signed [KW-1:0] k);
      logic signed [NW+KW-1:0] p;
      p = x * k;
      return NW'(p >>> EST_SHIFT);
   endfunction

   // correct the estimate and return the floor quotient and the remainder
   function automatic tma_carry_type carry_fix(input logic signed [NW-1:0] x,
                                               input logic signed [NW-1:0] q,
                                               input logic signed [11:0] radix);
      logic signed [NW-1:0] r;
      tma_carry_type res;
      r = x - q * radix;
      if (r < 0) begin
         res.q = q - NW'(1);
         r     = r + radix;
      end else if (r >= radix) begin
         res.q = q + NW'(1);
         r     = r - radix;
      end else begin
         res.q = q;
      end
      res.r = r[9:0];
      return res;
   endfunction

endpackage

@@ design/tma_front.sv @@
// input stage: sentinels, compare flags, add/sub/mul terms and first dividend
module tma_front import tma_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_vld,
   input  tma_req_type req,
   output logic        out_vld_ff,
   output tma_ctx_type out_ctx_ff,
   output tma_div_type out_div_ff
);

   logic               vld_in;
   tma_ctx_type        ctx_in;
   tma_div_type        div_in;
   logic               a_inf, b_inf, a_bad, b_bad;
   logic signed [6:0]  am_s, as_s, bm_s, bs_s;
   logic signed [10:0] ams_s, bms_s;
   logic signed [31:0] prod_h;
   logic signed [22:0] prod_m, prod_s;
   logic signed [26:0] prod_ms;
   logic signed [16:0] ah_w, ah_mag, f_w, f_mag;

   always_comb begin
      am_s  = signed'({1'b0, req.a_minutes});
      as_s  = signed'({1'b0, req.a_seconds});
      ams_s = signed'({1'b0, req.a_millis});
      bm_s  = signed'({1'b0, req.b_minutes});
      bs_s  = signed'({1'b0, req.b_seconds});
      bms_s = signed'({1'b0, req.b_millis});

      prod_h  = req.a_hours * req.factor;
      prod_m  = am_s * req.factor;
      prod_s  = as_s * req.factor;
      prod_ms = ams_s * req.factor;

      a_inf = req.a_hours == INF_HOURS && req.a_minutes == INF_MINUTES &&
              req.a_seconds == INF_SECONDS && req.a_millis == INF_MILLIS;
      b_inf = req.b_hours == INF_HOURS && req.b_minutes == INF_MINUTES &&
              req.b_seconds == INF_SECONDS && req.b_millis == INF_MILLIS;
      a_bad = req.a_hours == BAD_HOURS && req.a_minutes == 6'd0 &&
              req.a_seconds == 6'd0 && req.a_millis == 10'd0;
      b_bad = req.b_hours == BAD_HOURS && req.b_minutes == 6'd0 &&
              req.b_seconds == 6'd0 && req.b_millis == 10'd0;

      vld_in        = in_vld;
      ctx_in        = '0;
      ctx_in.is_div = req.action == ACT_DIV;
      ctx_in.fix    = FIX_NONE;
      ctx_in.a_m    = req.a_minutes;
      ctx_in.a_s    = req.a_seconds;
      ctx_in.a_ms   = req.a_millis;

      case (req.action)
         ACT_ADD: begin
            ctx_in.t_h  = 32'(req.a_hours) + 32'(req.b_hours);
            ctx_in.t_m  = NW'(am_s) + NW'(bm_s);
            ctx_in.t_s  = NW'(as_s) + NW'(bs_s);
            ctx_in.t_ms = NW'(ams_s) + NW'(bms_s);
            if (a_inf || b_inf) ctx_in.fix = FIX_INF;
            else if (a_bad || b_bad) ctx_in.fix = FIX_BAD;
         end
         ACT_SUB: begin
            ctx_in.t_h  = 32'(req.a_hours) - 32'(req.b_hours);
            ctx_in.t_m  = NW'(am_s) - NW'(bm_s);
            ctx_in.t_s  = NW'(as_s) - NW'(bs_s);
            ctx_in.t_ms = NW'(ams_s) - NW'(bms_s);
            if (a_inf || b_inf) ctx_in.fix = FIX_INF;
            else if (a_bad || b_bad) ctx_in.fix = FIX_BAD;
         end
         ACT_MUL: begin
            ctx_in.t_h  = prod_h;
            ctx_in.t_m  = NW'(prod_m);
            ctx_in.t_s  = NW'(prod_s);
            ctx_in.t_ms = NW'(prod_ms);
            if (a_inf) ctx_in.fix = FIX_INF;
            else if (a_bad) ctx_in.fix = FIX_BAD;
         end
         default: begin
            if (a_inf || req.factor == 16'sd0) ctx_in.fix = FIX_INF;
         end
      endcase

      ctx_in.less = req.a_hours < req.b_hours ||
                    (req.a_hours == req.b_hours && (req.a_minutes < req.b_minutes ||
                    (req.a_minutes == req.b_minutes && (req.a_seconds < req.b_seconds ||
                    (req.a_seconds == req.b_seconds && req.a_millis < req.b_millis)))));
      ctx_in.equal = req.a_hours == req.b_hours && req.a_minutes == req.b_minutes &&
                     req.a_seconds == req.b_seconds && req.a_millis == req.b_millis;

      f_w          = 17'(req.factor);
      f_mag        = (f_w < 0) ? -f_w : f_w;
      ctx_in.d_mag = f_mag[RW-1:0];
      ctx_in.d_neg = req.factor < 0;

      ah_w         = 17'(req.a_hours);
      ah_mag       = (ah_w < 0) ? -ah_w : ah_w;
      ctx_in.n_neg = req.a_hours < 0;
      div_in.num   = DW'(unsigned'(ah_mag));
      div_in.rem   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else out_vld_ff <= vld_in;
   end

   always_ff @(posedge clock) begin
      out_ctx_ff <= ctx_in;
      out_div_ff <= div_in;
   end

endmodule

@@ design/tma_div_cell.sv @@
// one restoring division step cell of the divider chain
module tma_div_cell import tma_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_vld,
   input  tma_ctx_type in_ctx,
   input  tma_div_type in_div,
   output logic        out_vld_ff,
   output tma_ctx_type out_ctx_ff,
   output tma_div_type out_div_ff
);

   logic          vld_in;
   tma_div_type   div_in;
   logic [RW:0]   sh;
   logic [RW:0]   diff;
   logic          take;

   always_comb begin
      vld_in = in_vld;
      sh     = {in_div.rem, in_div.num[DW-1]};
      diff   = sh - {1'b0, in_ctx.d_mag};
      take   = sh >= {1'b0, in_ctx.d_mag};
      div_in.rem = take ? diff[RW-1:0] : sh[RW-1:0];
      div_in.num = {in_div.num[DW-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else out_vld_ff <= vld_in;
   end

   always_ff @(posedge clock) begin
      out_ctx_ff <= in_ctx;
      out_div_ff <= div_in;
   end

endmodule

@@ design/tma_div_link.sv @@
// signs one finished quotient into its slot and forms the next dividend
module tma_div_link import tma_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  tma_slot_type slot,
   input  logic         in_vld,
   input  tma_ctx_type  in_ctx,
   input  tma_div_type  in_div,
   output logic         out_vld_ff,
   output tma_ctx_type  out_ctx_ff,
   output tma_div_type  out_div_ff
);

   logic                 vld_in;
   tma_ctx_type          ctx_in;
   tma_div_type          div_in;
   logic signed [NW-1:0] q_u, q, r, base, nd, nd_mag;
   logic signed [11:0]   radix;
   logic signed [RW:0]   r_u;

   always_comb begin
      vld_in = in_vld;
      q_u    = NW'(signed'({1'b0, in_div.num}));
      q      = (in_ctx.n_neg ^ in_ctx.d_neg) ? -q_u : q_u;
      r_u    = signed'({1'b0, in_div.rem});
      r      = in_ctx.n_neg ? -NW'(r_u) : NW'(r_u);

      ctx_in = in_ctx;
      case (slot)
         SLOT_H: begin
            if (in_ctx.is_div) ctx_in.t_h = 32'(q);
            base  = NW'(signed'({1'b0, in_ctx.a_m}));
            radix = SM_RADIX;
         end
         SLOT_M: begin
            if (in_ctx.is_div) ctx_in.t_m = q;
            base  = NW'(signed'({1'b0, in_ctx.a_s}));
            radix = SM_RADIX;
         end
         SLOT_S: begin
            if (in_ctx.is_div) ctx_in.t_s = q;
            base  = NW'(signed'({1'b0, in_ctx.a_ms}));
            radix = MS_RADIX;
         end
         default: begin
            if (in_ctx.is_div) ctx_in.t_ms = q;
            base  = '0;
            radix = '0;
         end
      endcase

      nd           = base + r * radix;
      nd_mag       = (nd < 0) ? -nd : nd;
      ctx_in.n_neg = nd < 0;
      div_in.num   = nd_mag[DW-1:0];
      div_in.rem   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else out_vld_ff <= vld_in;
   end

   always_ff @(posedge clock) begin
      out_ctx_ff <= ctx_in;
      out_div_ff <= div_in;
   end

endmodule

@@ design/tma_norm.sv @@
// floor-borrow normalization of ms, s and m, sentinel override, result register
module tma_norm import tma_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_vld,
   input  tma_ctx_type in_ctx,
   output logic        out_vld_ff,
   output tma_rsp_type out_rsp_ff
);

   logic [NORM_STAGES-2:0] vld_ff;
   logic [NORM_STAGES-1:0] vld_in;
   tma_ctx_type            ctx1_ff, ctx2_ff, ctx3_ff, ctx4_ff, ctx5_ff;
   tma_ctx_type            ctx2_in, ctx4_in;
   logic signed [NW-1:0]   est1_ff, est3_ff, est5_ff;
   logic signed [NW-1:0]   est1_in, est3_in, est5_in;
   tma_carry_type          cy2, cy4, cy6;
   tma_rsp_type            rsp_in;

   always_comb begin
      vld_in = {vld_ff, in_vld};

      est1_in = quot_est(in_ctx.t_ms, K_MS);

      cy2          = carry_fix(ctx1_ff.t_ms, est1_ff, MS_RADIX);
      ctx2_in      = ctx1_ff;
      ctx2_in.t_ms = NW'(signed'({1'b0, cy2.r}));
      ctx2_in.t_s  = ctx1_ff.t_s + cy2.q;

      est3_in = quot_est(ctx2_ff.t_s, K_SM);

      cy4         = carry_fix(ctx3_ff.t_s, est3_ff, SM_RADIX);
      ctx4_in     = ctx3_ff;
      ctx4_in.t_s = NW'(signed'({1'b0, cy4.r}));
      ctx4_in.t_m = ctx3_ff.t_m + cy4.q;

      est5_in = quot_est(ctx4_ff.t_m, K_SM);

      cy6            = carry_fix(ctx5_ff.t_m, est5_ff, SM_RADIX);
      rsp_in.a_less  = ctx5_ff.less;
      rsp_in.a_equal = ctx5_ff.equal;
      case (ctx5_ff.fix)
         FIX_INF: begin
            rsp_in.res_hours   = 32'(INF_HOURS);
            rsp_in.res_minutes = INF_MINUTES;
            rsp_in.res_seconds = INF_SECONDS;
            rsp_in.res_millis  = INF_MILLIS;
         end
         FIX_BAD: begin
            rsp_in.res_hours   = 32'(BAD_HOURS);
            rsp_in.res_minutes = '0;
            rsp_in.res_seconds = '0;
            rsp_in.res_millis  = '0;
         end
         default: begin
            rsp_in.res_hours   = ctx5_ff.t_h + 32'(cy6.q);
            rsp_in.res_minutes = cy6.r[5:0];
            rsp_in.res_seconds = ctx5_ff.t_s[5:0];
            rsp_in.res_millis  = ctx5_ff.t_ms[9:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= vld_in[NORM_STAGES-2:0];
         out_vld_ff <= vld_in[NORM_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      ctx1_ff    <= in_ctx;
      est1_ff    <= est1_in;
      ctx2_ff    <= ctx2_in;
      ctx3_ff    <= ctx2_ff;
      est3_ff    <= est3_in;
      ctx4_ff    <= ctx4_in;
      ctx5_ff    <= ctx4_ff;
      est5_ff    <= est5_in;
      out_rsp_ff <= rsp_in;
   end

endmodule

@@ design/mixed_radix_time_alu_top.sv @@
// top level of the mixed-radix time alu: front stage, divider cell rows, normalizer
//
// A request beat is taken in every cycle in which start is high; busy is high only
// while reset is asserted. Every operation, whatever its action, runs through the
// same pipeline and comes out on rsp_data with rsp_strobe high for exactly one
// cycle, in request order. The pipeline is one input stage, four rows of 25
// restoring-division step cells, one row per time field, each followed by a link
// stage, and a six-stage floor-borrow normalizer. The receiver must take each
// result in its strobe cycle.
module mixed_radix_time_alu_top import tma_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  tma_req_type req_data,
   output logic        rsp_strobe,
   output tma_rsp_type rsp_data
);

   logic        cell_vld [0:DIV_COUNT-1][0:DIV_STEPS];
   tma_ctx_type cell_ctx [0:DIV_COUNT-1][0:DIV_STEPS];
   tma_div_type cell_div [0:DIV_COUNT-1][0:DIV_STEPS];
   logic        link_vld [0:DIV_COUNT-1];
   tma_ctx_type link_ctx [0:DIV_COUNT-1];
   tma_div_type link_div [0:DIV_COUNT-1];

   assign busy = reset;

   tma_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_vld     (start && !busy),
      .req        (req_data),
      .out_vld_ff (cell_vld[0][0]),
      .out_ctx_ff (cell_ctx[0][0]),
      .out_div_ff (cell_div[0][0])
   );

   for (genvar k = 0; k < DIV_COUNT; k++) begin : g_row
      if (k > 0) begin : g_feed
         assign cell_vld[k][0] = link_vld[k-1];
         assign cell_ctx[k][0] = link_ctx[k-1];
         assign cell_div[k][0] = link_div[k-1];
      end
      for (genvar j = 0; j < DIV_STEPS; j++) begin : g_cell
         tma_div_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .in_vld     (cell_vld[k][j]),
            .in_ctx     (cell_ctx[k][j]),
            .in_div     (cell_div[k][j]),
            .out_vld_ff (cell_vld[k][j+1]),
            .out_ctx_ff (cell_ctx[k][j+1]),
            .out_div_ff (cell_div[k][j+1])
         );
      end
      tma_div_link u_link (
         .clock      (clock),
         .reset      (reset),
         .slot       (tma_slot_type'(k)),
         .in_vld     (cell_vld[k][DIV_STEPS]),
         .in_ctx     (cell_ctx[k][DIV_STEPS]),
         .in_div     (cell_div[k][DIV_STEPS]),
         .out_vld_ff (link_vld[k]),
         .out_ctx_ff (link_ctx[k]),
         .out_div_ff (link_div[k])
      );
   end

   tma_norm u_norm (
      .clock      (clock),
      .reset      (reset),
      .in_vld     (link_vld[DIV_COUNT-1]),
      .in_ctx     (link_ctx[DIV_COUNT-1]),
      .out_vld_ff (rsp_strobe),
      .out_rsp_ff (rsp_data)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.res_minutes <= 6'd59 && rsp_data.res_seconds <= 6'd59 &&
                      rsp_data.res_millis <= 10'd999))
      else $error("result fields not normalized");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result strobe without a request beat");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.a_equal) |-> !rsp_data.a_less)
      else $error("compare flags both set");

endmodule
